### hdl/rar_pkg.sv
// Package: shared types, widths and codes for the rational arithmetic reducer.
`timescale 1ns / 1ps
`default_nettype none
package rar_pkg;
  localparam int unsigned OperandWidth = 16;
  localparam int unsigned ProdWidth = 2 * OperandWidth;
  localparam int unsigned WideWidth = 2 * OperandWidth + 1;
  localparam int unsigned NumWidth = 33;
  localparam int unsigned DenWidth = 32;
  localparam int unsigned CntWidth = $clog2(WideWidth + 1);

  typedef enum logic [1:0] {
    CmdAdd = 2'd0,
    CmdSub = 2'd1,
    CmdMul = 2'd2,
    CmdDiv = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    StIdle,
    StProd,
    StCombine,
    StCheck,
    StRemStart,
    StRemRun,
    StRemNext,
    StQnStart,
    StQnRun,
    StQdStart,
    StQdRun,
    StOut
  } state_e;

  typedef enum logic [1:0] {
    DivRem,
    DivQuoN,
    DivQuoD
  } divsel_e;

  typedef struct packed {
    logic    load;
    logic    prod;
    logic    combine;
    logic    div_start;
    divsel_e div_sel;
    logic    div_step;
    logic    rem_shift;
    logic    take_qn;
    logic    take_qd;
    logic    out_load;
  } ctrl_t;

  typedef struct packed {
    logic d_zero;
    logic rem_zero;
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

### hdl/rar_if.sv
// Interfaces: valid/ready channels for operand beats and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface rar_in_if;
  import rar_pkg::*;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     command;
  logic signed [OperandWidth-1:0] num_a;
  logic signed [OperandWidth-1:0] den_a;
  logic signed [OperandWidth-1:0] num_b;
  logic signed [OperandWidth-1:0] den_b;
  modport source (output valid, command, num_a, den_a, num_b, den_b, input ready);
  modport sink (input valid, command, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rar_out_if;
  import rar_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [NumWidth-1:0] result_num;
  logic signed [DenWidth-1:0] result_den;
  logic                       zero_den_error;
  modport source (output valid, result_num, result_den, zero_den_error, input ready);
  modport sink (input valid, result_num, result_den, zero_den_error, output ready);
endinterface
`default_nettype wire

### hdl/rar_ctrl.sv
// Controller: sequences products, Euclid remainders and the two quotients.
`timescale 1ns / 1ps
`default_nettype none
module rar_ctrl
  import rar_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  input  wire   out_busy_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:     if (in_valid_i) state_d = StProd;
      StProd:     state_d = StCombine;
      StCombine:  state_d = StCheck;
      StCheck:    state_d = stat_i.d_zero ? StOut : StRemStart;
      StRemStart: state_d = StRemRun;
      StRemRun:   if (stat_i.div_done) state_d = StRemNext;
      StRemNext:  state_d = stat_i.rem_zero ? StQnStart : StRemStart;
      StQnStart:  state_d = StQnRun;
      StQnRun:    if (stat_i.div_done) state_d = StQdStart;
      StQdStart:  state_d = StQdRun;
      StQdRun:    if (stat_i.div_done) state_d = StOut;
      StOut:      if (!out_busy_i) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.div_sel = DivRem;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle:     begin
        in_ready_o = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      StProd:     ctrl_o.prod = 1'b1;
      StCombine:  ctrl_o.combine = 1'b1;
      StCheck:    ;
      StRemStart: begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_sel = DivRem;
      end
      StRemRun:   ctrl_o.div_step = 1'b1;
      StRemNext:  ctrl_o.rem_shift = !stat_i.rem_zero;
      StQnStart:  begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_sel = DivQuoN;
      end
      StQnRun:    begin
        ctrl_o.div_step = 1'b1;
        ctrl_o.take_qn = stat_i.div_done;
      end
      StQdStart:  begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_sel = DivQuoD;
      end
      StQdRun:    begin
        ctrl_o.div_step = 1'b1;
        ctrl_o.take_qd = stat_i.div_done;
      end
      StOut:      ctrl_o.out_load = !out_busy_i;
      default:    ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |=> state_q == StIdle)
    else $error("result load did not return to idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |=> state_q == StProd)
    else $error("operand beat did not start work");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !ctrl_o.div_step)
    else $error("divider stepping while idle");
endmodule
`default_nettype wire

### hdl/rar_dp.sv
// Datapath: products, raw fraction, restoring divider and Euclid registers.
`timescale 1ns / 1ps
`default_nettype none
module rar_dp
  import rar_pkg::*;
(
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire [1:0]                     command_i,
  input  wire signed [OperandWidth-1:0] num_a_i,
  input  wire signed [OperandWidth-1:0] den_a_i,
  input  wire signed [OperandWidth-1:0] num_b_i,
  input  wire signed [OperandWidth-1:0] den_b_i,
  input  ctrl_t                         ctrl_i,
  output stat_t                         stat_o,
  output logic signed [NumWidth-1:0]    num_o,
  output logic signed [DenWidth-1:0]    den_o,
  output logic                          err_o
);
  logic [1:0] cmd_q;
  logic signed [OperandWidth-1:0] na_q, da_q, nb_q, db_q;
  logic signed [ProdWidth-1:0] p0_q, p1_q, p2_q;
  logic signed [WideWidth-1:0] n_q, d_q, x_q, y_q, qn_q, qd_q;
  logic [WideWidth-1:0] dvd_q, dvs_q, quo_q, rem_q;
  logic neg_q, rneg_q, busy_q;
  logic [CntWidth-1:0] cnt_q;
  logic signed [WideWidth-1:0] a_sel, b_sel, rem_s, quo_s;
  logic [WideWidth:0] trial;
  logic [WideWidth-1:0] rsh;
  logic same;

  assign same = (da_q == db_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= command_i;
      na_q <= num_a_i;
      da_q <= den_a_i;
      nb_q <= num_b_i;
      db_q <= den_b_i;
    end
    if (ctrl_i.prod) begin
      unique case (cmd_e'(cmd_q))
        CmdMul: begin
          p0_q <= na_q * nb_q;
          p1_q <= '0;
          p2_q <= da_q * db_q;
        end
        CmdDiv: begin
          p0_q <= na_q * db_q;
          p1_q <= '0;
          p2_q <= da_q * nb_q;
        end
        default: begin
          p0_q <= na_q * db_q;
          p1_q <= nb_q * da_q;
          p2_q <= da_q * db_q;
        end
      endcase
    end
    if (ctrl_i.combine) begin
      priority if (cmd_q == CmdAdd && same) begin
        n_q <= WideWidth'(na_q) + WideWidth'(nb_q);
        d_q <= WideWidth'(da_q);
      end else if (cmd_q == CmdSub && same) begin
        n_q <= WideWidth'(na_q) - WideWidth'(nb_q);
        d_q <= WideWidth'(da_q);
      end else if (cmd_q == CmdAdd) begin
        n_q <= WideWidth'(p0_q) + WideWidth'(p1_q);
        d_q <= WideWidth'(p2_q);
      end else if (cmd_q == CmdSub) begin
        n_q <= WideWidth'(p0_q) - WideWidth'(p1_q);
        d_q <= WideWidth'(p2_q);
      end else begin
        n_q <= WideWidth'(p0_q);
        d_q <= WideWidth'(p2_q);
      end
    end
    if (ctrl_i.combine) begin
      x_q <= '0;
      y_q <= '0;
    end
    if (ctrl_i.div_start && ctrl_i.div_sel == DivRem && x_q == '0 && y_q == '0) begin
      x_q <= n_q;
      y_q <= d_q;
    end
    if (ctrl_i.rem_shift) begin
      x_q <= y_q;
      y_q <= rem_s;
    end
    if (ctrl_i.take_qn) qn_q <= quo_s;
    if (ctrl_i.take_qd) qd_q <= quo_s;
  end

  always_comb begin
    priority case (ctrl_i.div_sel)
      DivQuoN: begin
        a_sel = n_q;
        b_sel = y_q;
      end
      DivQuoD: begin
        a_sel = d_q;
        b_sel = y_q;
      end
      default: begin
        a_sel = (x_q == '0 && y_q == '0) ? n_q : x_q;
        b_sel = (x_q == '0 && y_q == '0) ? d_q : y_q;
      end
    endcase
  end

  assign rsh = {rem_q[WideWidth-2:0], dvd_q[WideWidth-1]};
  assign trial = {1'b0, rsh} - {1'b0, dvs_q};
  assign rem_s = rneg_q ? -$signed(rem_q) : $signed(rem_q);
  assign quo_s = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (ctrl_i.div_start) begin
      busy_q <= 1'b1;
      cnt_q <= CntWidth'(WideWidth);
    end else if (ctrl_i.div_step && busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_start) begin
      dvd_q <= a_sel[WideWidth-1] ? WideWidth'(-a_sel) : a_sel;
      dvs_q <= b_sel[WideWidth-1] ? WideWidth'(-b_sel) : b_sel;
      rem_q <= '0;
      quo_q <= '0;
      neg_q <= a_sel[WideWidth-1] ^ b_sel[WideWidth-1];
      rneg_q <= a_sel[WideWidth-1];
    end else if (ctrl_i.div_step && busy_q) begin
      dvd_q <= {dvd_q[WideWidth-2:0], 1'b0};
      if (!trial[WideWidth]) begin
        rem_q <= trial[WideWidth-1:0];
        quo_q <= {quo_q[WideWidth-2:0], 1'b1};
      end else begin
        rem_q <= rsh;
        quo_q <= {quo_q[WideWidth-2:0], 1'b0};
      end
    end
  end

  assign stat_o.d_zero = (d_q == '0);
  assign stat_o.rem_zero = (rem_q == '0);
  assign stat_o.div_done = ctrl_i.div_step && !busy_q;
  assign err_o = stat_o.d_zero;
  assign num_o = err_o ? '0 : NumWidth'(qn_q);
  assign den_o = err_o ? '0 : DenWidth'(qd_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.div_start |=> busy_q)
    else $error("divider failed to start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider count ran out while busy");
endmodule
`default_nettype wire

### hdl/rational_arith_reduce_core.sv
// Top level: rational add/sub/mul/div with Euclid gcd reduction.
//  channel   dir  payload
//  in_ch     in   command, num_a, den_a, num_b, den_b
//  out_ch    out  result_num, result_den, zero_den_error
// One beat at a time: products, combine and check, then straight to output when the raw
// denominator is zero, otherwise one division per Euclid remainder step and two for the
// quotients, all in the one-bit-a-cycle restoring divider.
// Reset clears the controller and the output valid. A result beat waits in
// the output register; the next operand beat is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_reduce_core
  import rar_pkg::*;
(
  input  wire clk_i,
  input  wire rst_ni,
  rar_in_if.sink    in_ch,
  rar_out_if.source out_ch
);
  ctrl_t ctrl;
  stat_t stat;
  logic signed [NumWidth-1:0] num;
  logic signed [DenWidth-1:0] den;
  logic err, ovalid_q, in_ready;

  assign in_ch.ready = in_ready;

  rar_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid),
    .in_ready_o(in_ready),
    .out_busy_i(ovalid_q && !out_ch.ready),
    .stat_i(stat),
    .ctrl_o(ctrl)
  );

  rar_dp u_dp (
    .clk_i, .rst_ni,
    .command_i(in_ch.command),
    .num_a_i(in_ch.num_a),
    .den_a_i(in_ch.den_a),
    .num_b_i(in_ch.num_b),
    .den_b_i(in_ch.den_b),
    .ctrl_i(ctrl),
    .stat_o(stat),
    .num_o(num),
    .den_o(den),
    .err_o(err)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (ctrl.out_load) ovalid_q <= 1'b1;
    else if (out_ch.ready) ovalid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_ch.result_num <= num;
      out_ch.result_den <= den;
      out_ch.zero_den_error <= err;
    end
  end

  assign out_ch.valid = ovalid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> !ovalid_q || out_ch.ready)
    else $error("result overwritten before taken");
endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench: self-checking stimulus and result checks for the rational arithmetic reducer.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import rar_pkg::*;

  typedef struct {
    cmd_e             cmd;
    logic signed [15:0] na, da, nb, db;
  } operands_t;

  typedef struct {
    logic signed [NumWidth-1:0] num;
    logic signed [DenWidth-1:0] den;
    logic                       err;
  } fraction_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  rar_in_if  in_ch ();
  rar_out_if out_ch ();

  rational_arith_reduce_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  operands_t pending_q[$];
  fraction_t reduced_q[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  int        hold_off = 0;
  bit        stall_go = 1'b0;
  bit        stall_used = 1'b0;
  bit        calm = 1'b0;
  bit        stim_done = 1'b0;
  logic      in_taken = 1'b0;

  function automatic longint gcd_trunc(longint x, longint y);
    longint r;
    r = x % y;
    while (r != 0) begin
      x = y;
      y = r;
      r = x % y;
    end
    return y;
  endfunction

  function automatic fraction_t reduce_fraction(operands_t op);
    longint    n, d, g, na, da, nb, db;
    fraction_t f;
    na = op.na;
    da = op.da;
    nb = op.nb;
    db = op.db;
    case (op.cmd)
      CmdAdd: begin
        if (da == db) begin
          n = na + nb;
          d = da;
        end else begin
          n = na * db + nb * da;
          d = da * db;
        end
      end
      CmdSub: begin
        if (da == db) begin
          n = na - nb;
          d = da;
        end else begin
          n = na * db - nb * da;
          d = da * db;
        end
      end
      CmdMul: begin
        n = na * nb;
        d = da * db;
      end
      default: begin
        n = na * db;
        d = da * nb;
      end
    endcase
    if (d == 0) begin
      f.num = '0;
      f.den = '0;
      f.err = 1'b1;
    end else begin
      g = gcd_trunc(n, d);
      f.num = NumWidth'(n / g);
      f.den = DenWidth'(d / g);
      f.err = 1'b0;
    end
    return f;
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4, 5: return 16'($signed($urandom_range(0, 24)) - 12);
      6: return 16'($urandom_range(1, 200));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push(cmd_e c, int na, int da, int nb, int db);
    operands_t op;
    op.cmd = c;
    op.na = 16'(na);
    op.da = 16'(da);
    op.nb = 16'(nb);
    op.db = 16'(db);
    pending_q.push_back(op);
  endtask

  // hold the valid check at the falling edge in step with acceptance at the rising one
  always @(posedge clk_i) in_taken <= in_ch.valid && in_ch.ready;

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid   <= 1'b0;
      in_ch.command <= '0;
      in_ch.num_a   <= '0;
      in_ch.den_a   <= '0;
      in_ch.num_b   <= '0;
      in_ch.den_b   <= '0;
      send_gap      <= 0;
    end else if (in_ch.valid !== 1'b1 || in_taken) begin
      if (in_ch.valid) begin
        reduced_q.push_back(reduce_fraction(pending_q.pop_front()));
      end
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap    <= send_gap - 1;
      end else if (pending_q.size() > 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.command <= pending_q[0].cmd;
        in_ch.num_a   <= pending_q[0].na;
        in_ch.den_a   <= pending_q[0].da;
        in_ch.num_b   <= pending_q[0].nb;
        in_ch.den_b   <= pending_q[0].db;
        if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 15);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= 0;
      hold_off     <= 0;
      stall_used   <= 1'b0;
    end else if (stall_go && !stall_used) begin
      out_ch.ready <= 1'b0;
      hold_off     <= 400;
      stall_used   <= 1'b1;
    end else if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off     <= hold_off - 1;
    end else if (recv_gap > 0) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= recv_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 6) == 0) recv_gap <= $urandom_range(1, 15);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (reduced_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result beat num=%0d den=%0d err=%0b",
                                      out_ch.result_num, out_ch.result_den,
                                      out_ch.zero_den_error);
      end else begin
        fraction_t e;
        e = reduced_q.pop_front();
        if (out_ch.result_num !== e.num || out_ch.result_den !== e.den ||
            out_ch.zero_den_error !== e.err) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp %0d/%0d err=%0b, got %0d/%0d err=%0b",
                     e.num, e.den, e.err, out_ch.result_num, out_ch.result_den,
                     out_ch.zero_den_error);
        end
      end
    end
  end

  initial begin
    int limit;
    limit = 5000000;
    wait (cycles >= limit);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int i;
    int k;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push(CmdAdd, 1, 2, 1, 3);
    push(CmdAdd, 3, 4, 5, 4);
    push(CmdSub, 1, 2, 1, 3);
    push(CmdSub, 7, 6, 7, 6);
    push(CmdMul, 2, 3, 9, 4);
    push(CmdDiv, 2, 3, 9, 4);
    push(CmdAdd, 1, 0, 1, 0);
    push(CmdMul, 5, 0, 5, 7);
    push(CmdDiv, 5, 7, 0, 3);
    push(CmdAdd, 0, 5, 0, 7);
    push(CmdMul, 0, -5, 3, 7);
    push(CmdSub, 3, -4, 1, 6);
    push(CmdDiv, -3, 4, -5, 8);
    push(CmdMul, -32768, -32768, -32768, -32768);
    push(CmdMul, -32768, 32767, 32767, -32768);
    push(CmdAdd, 32767, -32768, 32767, 32767);
    push(CmdSub, -32768, 32767, 32767, -32768);
    push(CmdDiv, 32767, -32768, -32768, 32767);
    push(CmdAdd, -1, -1, -1, -1);
    push(CmdSub, 0, -1, 0, 1);
    wait (pending_q.size() == 0);

    // long stall: fill the block while the sender keeps offering
    @(negedge clk_i);
    stall_go = 1'b1;
    for (i = 0; i < 8; i++) push(cmd_e'(i[1:0]), i + 3, 5, 7, i + 2);
    wait (stall_used);
    wait (pending_q.size() == 0 && hold_off == 0);

    for (i = 0; i < 430; i++) begin
      operands_t op;
      if (i == 380) calm = 1'b1;
      op.cmd = cmd_e'($urandom_range(0, 3));
      op.na = pick_value();
      op.da = pick_value();
      op.nb = pick_value();
      op.db = ($urandom_range(0, 3) == 0) ? op.da : pick_value();
      pending_q.push_back(op);
      k = 0;
      while (pending_q.size() > 4 && k < 1000000) begin
        @(negedge clk_i);
        k++;
      end
    end
    wait (pending_q.size() == 0 && !in_ch.valid);
    wait (reduced_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && reduced_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
hdl/rar_pkg.sv
hdl/rar_if.sv
hdl/rar_ctrl.sv
hdl/rar_dp.sv
hdl/rational_arith_reduce_core.sv
tb/tb_top.sv
